>>> rtl/wsfd_pkg.sv
// Shared types, opcodes and helpers for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned TUSER_W  = 7;

    localparam logic [OPCODE_W-1:0] OPC_CONT  = 4'h0;
    localparam logic [OPCODE_W-1:0] OPC_CLOSE = 4'h8;
    localparam logic [OPCODE_W-1:0] OPC_PING  = 4'h9;
    localparam logic [OPCODE_W-1:0] OPC_PONG  = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic                end_of_message;
        logic                is_control;
        logic                opcode_known;
        logic [OPCODE_W-1:0] msg_opcode;
        logic                has_byte;
        logic [BYTE_W-1:0]   payload_byte;
    } t_result;

    function automatic logic is_control_op(input logic [OPCODE_W-1:0] op);
        return (op == OPC_CLOSE) || (op == OPC_PING) || (op == OPC_PONG);
    endfunction

endpackage

>>> rtl/wsfd_out_skid.sv
// Output register with a skid stage for deframer results.
`timescale 1ns / 1ps

module wsfd_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsfd_pkg::t_result i_result,
    output logic              o_can_accept,
    output logic              o_valid,
    output wsfd_pkg::t_result o_result,
    input  logic              i_take
);
    import wsfd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free     = !r_out_valid || i_take;
    assign o_can_accept = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out        <= r_skid;
                    r_skid_valid <= i_push;
                    if (i_push) begin
                        r_skid <= i_result;
                    end
                end else begin
                    r_out_valid <= i_push;
                    if (i_push) begin
                        r_out <= i_result;
                    end
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_result;
            end
        end
    end

endmodule

>>> rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: header parser, unmasking and output stage.
`timescale 1ns / 1ps
// Output: a payload byte or empty end marker is registered in the output stage, or in
// the skid stage while the master side stalls, when its input byte is transferred.
// Throughput: one input byte per cycle while the skid stage is empty; output register
// and skid stage keep the input side open while one result waits for the master side.
// Reset: synchronous, active low; the parser returns to the first header byte.

module websocket_frame_deframer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0]           i_s_tdata,   // [7:0] rx_byte
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [wsfd_pkg::BYTE_W-1:0]           o_m_tdata,   // [7:0] payload_byte
    output logic [wsfd_pkg::TUSER_W-1:0]          o_m_tuser,   // [0] has_byte,
                                                               // [4:1] msg_opcode,
                                                               // [5] opcode_known,
                                                               // [6] is_control
    output logic                                  o_m_tlast    // end_of_message
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    t_phase              r_phase,        n_phase;
    logic [2:0]          r_ext_cnt,      n_ext_cnt;
    logic [LEN_W-1:0]    r_rem_len,      n_rem_len;
    logic [KEY_W-1:0]    r_mask_key,     n_mask_key;
    logic                r_mask_en,      n_mask_en;
    logic                r_fin,          n_fin;
    logic [OPCODE_W-1:0] r_frame_op,     n_frame_op;
    logic [OPCODE_W-1:0] r_data_op,      n_data_op;
    logic                r_data_op_vld,  n_data_op_vld;
    logic [1:0]          r_mask_idx,     n_mask_idx;

    logic    accept;
    logic    can_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_s_tready = can_accept;
    assign accept     = i_s_tvalid && can_accept;

    always_comb begin
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  dec;
        logic [BYTE_W-1:0] kb;
        logic              ctl;
        logic              hdr_done;
        logic              after_len;
        logic              eom;
        logic              emit;
        logic              has;
        logic [BYTE_W-1:0] byte_out;

        b         = i_s_tdata;
        len       = r_rem_len;
        dec       = r_rem_len - LEN_W'(1);
        kb        = '0;
        ctl       = is_control_op(r_frame_op);
        hdr_done  = 1'b0;
        after_len = 1'b0;
        eom       = 1'b0;
        emit      = 1'b0;
        has       = 1'b0;
        byte_out  = '0;

        n_phase       = r_phase;
        n_ext_cnt     = r_ext_cnt;
        n_rem_len     = r_rem_len;
        n_mask_key    = r_mask_key;
        n_mask_en     = r_mask_en;
        n_fin         = r_fin;
        n_frame_op    = r_frame_op;
        n_data_op     = r_data_op;
        n_data_op_vld = r_data_op_vld;
        n_mask_idx    = r_mask_idx;

        case (r_phase)
            PH_HDR1: begin
                n_mask_en = b[7];
                n_ext_cnt = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    n_rem_len = '0;
                    n_phase   = PH_EXT16;
                end else if (b[6:0] == LEN7_EXT64) begin
                    n_rem_len = '0;
                    n_phase   = PH_EXT64;
                end else begin
                    len       = LEN_W'(b[6:0]);
                    n_rem_len = len;
                    after_len = 1'b1;
                end
            end
            PH_EXT16: begin
                len       = {r_rem_len[LEN_W-BYTE_W-1:0], b};
                n_rem_len = len;
                n_ext_cnt = r_ext_cnt + 3'd1;
                if (r_ext_cnt == 3'd1) begin
                    after_len = 1'b1;
                end
            end
            PH_EXT64: begin
                len       = {r_rem_len[LEN_W-BYTE_W-1:0], b};
                n_rem_len = len;
                if (r_ext_cnt == 3'd7) begin
                    after_len = 1'b1;
                end else begin
                    n_ext_cnt = r_ext_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_mask_key = {r_mask_key[KEY_W-BYTE_W-1:0], b};
                n_ext_cnt  = r_ext_cnt + 3'd1;
                if (r_ext_cnt == 3'd3) begin
                    n_ext_cnt = '0;
                    hdr_done  = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                case (r_mask_idx)
                    2'd0:    kb = r_mask_key[31:24];
                    2'd1:    kb = r_mask_key[23:16];
                    2'd2:    kb = r_mask_key[15:8];
                    default: kb = r_mask_key[7:0];
                endcase
                n_rem_len  = dec;
                n_mask_idx = r_mask_idx + 2'd1;
                emit       = 1'b1;
                has        = 1'b1;
                byte_out   = b ^ kb;
                if (dec == '0) begin
                    n_phase = PH_HDR0;
                    eom     = ctl || r_fin;
                end
            end
            default: begin
                n_fin      = b[7];
                n_frame_op = b[OPCODE_W-1:0];
                if (b[OPCODE_W-1:0] != OPC_CONT && !is_control_op(b[OPCODE_W-1:0])) begin
                    n_data_op     = b[OPCODE_W-1:0];
                    n_data_op_vld = 1'b1;
                end
                n_phase = PH_HDR1;
            end
        endcase

        if (after_len) begin
            n_ext_cnt  = '0;
            n_mask_key = '0;
            if (n_mask_en) begin
                n_phase = PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_mask_idx = '0;
            if (len != '0) begin
                n_phase = PH_PAYLOAD;
            end else begin
                n_phase = PH_HDR0;
                if (ctl || r_fin) begin
                    emit = 1'b1;
                    eom  = 1'b1;
                end
            end
        end

        res.payload_byte   = byte_out;
        res.has_byte       = has;
        res.msg_opcode     = ctl ? r_frame_op : (r_data_op_vld ? r_data_op : '0);
        res.opcode_known   = ctl || r_data_op_vld;
        res.is_control     = ctl;
        res.end_of_message = eom;
        res_valid          = accept && emit;

        if (emit && eom && !ctl) begin
            n_data_op_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_ext_cnt     <= '0;
            r_rem_len     <= '0;
            r_mask_key    <= '0;
            r_mask_en     <= 1'b0;
            r_fin         <= 1'b0;
            r_frame_op    <= '0;
            r_data_op     <= '0;
            r_data_op_vld <= 1'b0;
            r_mask_idx    <= '0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_ext_cnt     <= n_ext_cnt;
            r_rem_len     <= n_rem_len;
            r_mask_key    <= n_mask_key;
            r_mask_en     <= n_mask_en;
            r_fin         <= n_fin;
            r_frame_op    <= n_frame_op;
            r_data_op     <= n_data_op;
            r_data_op_vld <= n_data_op_vld;
            r_mask_idx    <= n_mask_idx;
        end
    end

    wsfd_out_skid u_out_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_result     (res),
        .o_can_accept (can_accept),
        .o_valid      (o_m_tvalid),
        .o_result     (out_res),
        .i_take       (i_m_tready)
    );

    assign o_m_tdata = out_res.payload_byte;
    assign o_m_tuser = {out_res.is_control, out_res.opcode_known,
                        out_res.msg_opcode, out_res.has_byte};
    assign o_m_tlast = out_res.end_of_message;

endmodule

>>> dv/websocket_frame_deframer_checker.sv
// Checker for the WebSocket frame deframer: predicts each output transfer and compares it.
`timescale 1ns / 1ps

module websocket_frame_deframer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0]  i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0]  i_m_tdata,
    input  logic [wsfd_pkg::TUSER_W-1:0] i_m_tuser,
    input  logic                         i_m_tlast,
    output int                           o_mismatches,
    output int                           o_pending
);
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        P_HDR0,
        P_HDR1,
        P_EXT16,
        P_EXT64,
        P_MASK_KEY,
        P_PAYLOAD
    } t_parse_phase;

    t_parse_phase        phase;
    logic [2:0]          len_byte_cnt;
    logic [LEN_W-1:0]    bytes_left;
    logic [KEY_W-1:0]    key;
    logic                masked;
    logic                fin;
    logic [OPCODE_W-1:0] frame_op;
    logic [OPCODE_W-1:0] data_op;
    logic                data_op_valid;
    logic [1:0]          key_idx;

    int mismatch_count = 0;
    int pending_count  = 0;

    // New entries go in at the front and the oldest leaves from the back.
    t_result expected_payload[$];

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic is_ctrl_frame(input logic [OPCODE_W-1:0] op);
        return (op == OPC_CLOSE) || (op == OPC_PING) || (op == OPC_PONG);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("checker: %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic add_result(input logic [BYTE_W-1:0] b, input logic has, input logic eom);
        t_result r;
        logic    ctl;
        ctl              = is_ctrl_frame(frame_op);
        r.payload_byte   = b;
        r.has_byte       = has;
        r.msg_opcode     = ctl ? frame_op : (data_op_valid ? data_op : OPC_CONT);
        r.opcode_known   = ctl | data_op_valid;
        r.is_control     = ctl;
        r.end_of_message = eom;
        expected_payload.push_front(r);
        if (eom && !ctl) begin
            data_op_valid = 1'b0;
        end
    endtask

    task automatic header_finished();
        key_idx = 2'd0;
        if (bytes_left != '0) begin
            phase = P_PAYLOAD;
        end else begin
            phase = P_HDR0;
            if (is_ctrl_frame(frame_op) || fin) begin
                add_result('0, 1'b0, 1'b1);
            end
        end
    endtask

    task automatic length_known();
        len_byte_cnt = 3'd0;
        key          = '0;
        if (masked) begin
            phase = P_MASK_KEY;
        end else begin
            header_finished();
        end
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] key_byte;
        logic              last;
        case (phase)
            P_HDR1: begin
                masked       = b[7];
                len_byte_cnt = 3'd0;
                bytes_left   = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    phase = P_EXT16;
                end else if (b[6:0] == LEN7_EXT64) begin
                    phase = P_EXT64;
                end else begin
                    bytes_left = {57'd0, b[6:0]};
                    length_known();
                end
            end
            P_EXT16: begin
                bytes_left   = {bytes_left[LEN_W-9:0], b};
                len_byte_cnt = len_byte_cnt + 3'd1;
                if (len_byte_cnt == 3'd2) begin
                    length_known();
                end
            end
            P_EXT64: begin
                bytes_left = {bytes_left[LEN_W-9:0], b};
                if (len_byte_cnt == 3'd7) begin
                    length_known();
                end else begin
                    len_byte_cnt = len_byte_cnt + 3'd1;
                end
            end
            P_MASK_KEY: begin
                key          = {key[KEY_W-9:0], b};
                len_byte_cnt = len_byte_cnt + 3'd1;
                if (len_byte_cnt == 3'd4) begin
                    len_byte_cnt = 3'd0;
                    header_finished();
                end
            end
            P_PAYLOAD: begin
                key_byte   = key[8 * (3 - int'(key_idx)) +: 8];
                bytes_left = bytes_left - LEN_W'(1);
                key_idx    = key_idx + 2'd1;
                last       = (bytes_left == '0);
                if (last) begin
                    phase = P_HDR0;
                end
                add_result(b ^ key_byte, 1'b1, last && (is_ctrl_frame(frame_op) || fin));
            end
            default: begin
                fin      = b[7];
                frame_op = b[3:0];
                if (frame_op != OPC_CONT && !is_ctrl_frame(frame_op)) begin
                    data_op       = frame_op;
                    data_op_valid = 1'b1;
                end
                phase = P_HDR1;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase         = P_HDR0;
            len_byte_cnt  = 3'd0;
            bytes_left    = '0;
            key           = '0;
            masked        = 1'b0;
            fin           = 1'b0;
            frame_op      = OPC_CONT;
            data_op       = OPC_CONT;
            data_op_valid = 1'b0;
            key_idx       = 2'd0;
            expected_payload.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_payload.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected transfer, tdata %02h tuser %02h tlast %0b",
                        i_m_tdata, i_m_tuser, i_m_tlast));
                end else begin
                    want = expected_payload.pop_back();
                    check_field("payload_byte", i_m_tdata, want.payload_byte);
                    check_field("has_byte", 8'(i_m_tuser[0]), 8'(want.has_byte));
                    check_field("msg_opcode", 8'(i_m_tuser[4:1]), 8'(want.msg_opcode));
                    check_field("opcode_known", 8'(i_m_tuser[5]), 8'(want.opcode_known));
                    check_field("is_control", 8'(i_m_tuser[6]), 8'(want.is_control));
                    check_field("end_of_message", 8'(i_m_tlast), 8'(want.end_of_message));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata);
            end
        end
        pending_count = expected_payload.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for the WebSocket frame deframer: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import wsfd_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [3:0]  OPC_TEXT    = 4'h1;
    localparam logic [3:0]  OPC_BIN     = 4'h2;

    typedef enum int {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } t_len_form;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [BYTE_W-1:0]  i_s_tdata  = '0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [BYTE_W-1:0]  o_m_tdata;
    logic [TUSER_W-1:0] o_m_tuser;
    logic               o_m_tlast;

    int mismatches;
    int pending;
    int cycle_count    = 0;
    int send_idle_pct  = 8;
    int recv_idle_pct  = 59;
    int bytes_sent     = 0;
    logic msg_open     = 1'b0;
    // Bytes go in at the front and leave from the back.
    logic [BYTE_W-1:0] wire_bytes[$];

    websocket_frame_deframer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    websocket_frame_deframer_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // A negative fill value gives random payload bytes.
    task automatic build_frame(input logic [7:0] hdr0, input logic masked,
                               input logic [31:0] key, input int unsigned len,
                               input t_len_form form, input int fill);
        logic [63:0] len64;
        len64 = 64'(len);
        wire_bytes.push_front(hdr0);
        case (form)
            LEN_SHORT: begin
                wire_bytes.push_front({masked, len64[6:0]});
            end
            LEN_16: begin
                wire_bytes.push_front({masked, LEN7_EXT16});
                wire_bytes.push_front(len64[15:8]);
                wire_bytes.push_front(len64[7:0]);
            end
            default: begin
                wire_bytes.push_front({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--) begin
                    wire_bytes.push_front(len64[8 * i +: 8]);
                end
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) begin
                wire_bytes.push_front(key[8 * i +: 8]);
            end
        end
        for (int unsigned i = 0; i < len; i++) begin
            wire_bytes.push_front((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        end
    endtask

    task automatic send_queued_bytes();
        while (wire_bytes.size() > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= wire_bytes.pop_back();
            do @(posedge i_clk); while (!o_s_tready);
            bytes_sent++;
        end
    endtask

    task automatic random_traffic(input int n_bytes);
        int          start;
        int          sel;
        int          r;
        logic [7:0]  hdr0;
        logic [3:0]  op;
        logic [2:0]  rsv;
        int unsigned len;
        t_len_form   form;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            sel  = $urandom_range(99);
            form = LEN_SHORT;
            if (sel < 10) begin
                hdr0 = 8'($urandom_range(255));
            end else if (sel < 30) begin
                case ($urandom_range(2))
                    0: op = OPC_CLOSE;
                    1: op = OPC_PING;
                    default: op = OPC_PONG;
                endcase
                hdr0 = {1'b1, 3'b000, op};
            end else begin
                if (msg_open) begin
                    op = OPC_CONT;
                end else begin
                    r = $urandom_range(99);
                    if (r < 45) begin
                        op = OPC_TEXT;
                    end else if (r < 80) begin
                        op = OPC_BIN;
                    end else begin
                        do op = 4'($urandom_range(15, 3));
                        while (op == OPC_CLOSE || op == OPC_PING || op == OPC_PONG);
                    end
                end
                rsv  = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'b000;
                hdr0 = {($urandom_range(99) < 40), rsv, op};
            end
            if (sel >= 10 && sel < 30) begin
                len = $urandom_range(12);
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    len = $urandom_range(12);
                end else if (r < 75) begin
                    len = $urandom_range(125);
                end else if (r < 90) begin
                    len  = $urandom_range(300);
                    form = LEN_16;
                end else begin
                    len  = $urandom_range(40);
                    form = LEN_64;
                end
            end
            op = hdr0[3:0];
            if (!(op == OPC_CLOSE || op == OPC_PING || op == OPC_PONG)) begin
                if (op != OPC_CONT) begin
                    msg_open = 1'b1;
                end
                if (hdr0[7]) begin
                    msg_open = 1'b0;
                end
            end
            build_frame(hdr0, 1'($urandom_range(1)), $urandom, len, form, -1);
            send_queued_bytes();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Continuation before any data opcode, then an empty ping.
        build_frame({1'b1, 3'b000, OPC_CONT}, 1'b0, 32'h0, 1, LEN_SHORT, 8'hFF);
        build_frame({1'b1, 3'b000, OPC_PING}, 1'b0, 32'h0, 0, LEN_SHORT, 0);
        // An empty non-final text frame opens a message; a masked pong interrupts it.
        build_frame({1'b0, 3'b000, OPC_TEXT}, 1'b0, 32'h0, 0, LEN_SHORT, 0);
        build_frame({1'b1, 3'b000, OPC_PONG}, 1'b1, 32'hFF00_A55A, 1, LEN_SHORT, 8'h00);
        build_frame({1'b1, 3'b000, OPC_CONT}, 1'b0, 32'h0, 1, LEN_16, 8'h00);
        // Reserved opcode with all RSV bits set, masked, 64-bit length.
        build_frame({1'b1, 3'b111, 4'hF}, 1'b1, 32'hFFFF_FFFF, 2, LEN_64, 8'hFF);
        build_frame({1'b1, 3'b000, OPC_CLOSE}, 1'b0, 32'h0, 0, LEN_SHORT, 0);
        build_frame({1'b1, 3'b000, OPC_BIN}, 1'b0, 32'h0, 0, LEN_SHORT, 0);
        send_queued_bytes();

        random_traffic(630);
        send_idle_pct = 59;
        recv_idle_pct = 8;
        random_traffic(630);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(630);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wsfd_pkg.sv
rtl/wsfd_out_skid.sv
rtl/websocket_frame_deframer_unit.sv
dv/websocket_frame_deframer_checker.sv
dv/tb.sv
